// ===== design/lcs_pkg.sv =====
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared types, constants and letter decode functions for the letter class
// sort block.
// ----------------------------------------------------------------------------
package lcs_pkg;

    localparam int LCS_MAX_LETTERS    = 32;
    localparam int LCS_NUM_BINS       = 52;
    localparam int LCS_NUM_VOWEL_BINS = 10;
    localparam int LCS_BIN_W          = 6;
    localparam int LCS_CNT_W          = 6;
    localparam int LCS_TOT_W          = LCS_CNT_W + 1;

    localparam logic [7:0] LCS_CHR_UP_A = 8'h41;
    localparam logic [7:0] LCS_CHR_UP_Z = 8'h5A;
    localparam logic [7:0] LCS_CHR_LO_A = 8'h61;
    localparam logic [7:0] LCS_CHR_LO_Z = 8'h7A;

    localparam logic [0:0] LCS_GRP_VOWEL     = 1'b0;
    localparam logic [0:0] LCS_GRP_CONSONANT = 1'b1;

    // emit order: vowel bins first, then consonant bins, each ascending
    localparam logic [LCS_BIN_W-1:0] LCS_ORDER [LCS_NUM_BINS] = '{
        6'd0,  6'd4,  6'd8,  6'd14, 6'd20, 6'd26, 6'd30, 6'd34, 6'd40, 6'd46,
        6'd1,  6'd2,  6'd3,  6'd5,  6'd6,  6'd7,  6'd9,  6'd10, 6'd11, 6'd12,
        6'd13, 6'd15, 6'd16, 6'd17, 6'd18, 6'd19, 6'd21, 6'd22, 6'd23, 6'd24,
        6'd25, 6'd27, 6'd28, 6'd29, 6'd31, 6'd32, 6'd33, 6'd35, 6'd36, 6'd37,
        6'd38, 6'd39, 6'd41, 6'd42, 6'd43, 6'd44, 6'd45, 6'd47, 6'd48, 6'd49,
        6'd50, 6'd51
    };

    typedef struct packed {
        logic accept;
        logic update;
        logic seq_clear;
        logic seq_read;
        logic take_cnt;
        logic next_bin;
        logic emit;
        logic emit_empty;
        logic clear_all;
    } t_cmd;

    typedef struct packed {
        logic eot;
        logic total_zero;
        logic cnt_zero;
        logic left_one;
        logic last_bin;
        logic is_last;
        logic out_free;
    } t_status;

    function automatic logic is_upper(input logic [7:0] c);
        return (c >= LCS_CHR_UP_A) && (c <= LCS_CHR_UP_Z);
    endfunction

    function automatic logic is_lower(input logic [7:0] c);
        return (c >= LCS_CHR_LO_A) && (c <= LCS_CHR_LO_Z);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return is_upper(c) || is_lower(c);
    endfunction

    function automatic logic [LCS_BIN_W-1:0] letter_bin(input logic [7:0] c);
        logic [7:0] b;
        if (is_upper(c)) begin
            b = c - LCS_CHR_UP_A;
        end else if (is_lower(c)) begin
            b = c - LCS_CHR_LO_A + 8'd26;
        end else begin
            b = '0;
        end
        return b[LCS_BIN_W-1:0];
    endfunction

    function automatic logic is_vowel(input logic [7:0] c);
        logic [7:0] low;
        low = c | 8'h20;
        return (low == 8'h61) || (low == 8'h65) || (low == 8'h69) ||
               (low == 8'h6F) || (low == 8'h75);
    endfunction

    function automatic logic [6:0] bin_code(input logic [LCS_BIN_W-1:0] b);
        logic [6:0] code;
        if (b < 6'd26) begin
            code = 7'h41 + 7'(b);
        end else begin
            code = 7'h47 + 7'(b);
        end
        return code;
    endfunction

endpackage

// ===== design/lcs_datapath.sv =====
// ----------------------------------------------------------------------------
// lcs_datapath
// Histogram memory, group totals, emit sequence counters and the output
// register of the letter class sort block.
// ----------------------------------------------------------------------------
module lcs_datapath
    import lcs_pkg::*;
#(
    parameter int MAX_LETTERS = LCS_MAX_LETTERS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [7:0]           i_char_code,
    input  logic                 i_end_of_text,
    input  logic                 i_stall,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    output logic                 o_valid,
    output logic [6:0]           o_letter,
    output logic                 o_group,
    output logic [LCS_CNT_W-1:0] o_group_count,
    output logic                 o_overflowed,
    output logic                 o_empty_text,
    output logic                 o_last_result
);

    logic [LCS_CNT_W-1:0] r_hist [LCS_NUM_BINS];
    logic [LCS_NUM_BINS-1:0] r_bin_valid;
    logic [LCS_CNT_W-1:0] r_rd_data;
    logic                 r_rd_hit;

    logic [LCS_BIN_W-1:0] r_bin;
    logic                 r_is_letter;
    logic                 r_is_vowel;
    logic                 r_eot;

    logic [LCS_CNT_W-1:0] r_vowel_total;
    logic [LCS_CNT_W-1:0] r_cons_total;
    logic                 r_overflow;

    logic [LCS_BIN_W-1:0] r_idx;
    logic [LCS_CNT_W-1:0] r_left;
    logic [LCS_CNT_W-1:0] r_emitted;

    logic                 r_o_valid;
    logic [6:0]           r_letter;
    logic                 r_group;
    logic [LCS_CNT_W-1:0] r_group_count;
    logic                 r_overflowed;
    logic                 r_empty_text;
    logic                 r_last_result;

    logic [LCS_BIN_W-1:0] w_rd_addr;
    logic [LCS_BIN_W-1:0] w_seq_bin;
    logic [LCS_CNT_W-1:0] w_rd_cnt;
    logic [LCS_TOT_W-1:0] w_total;
    logic                 w_room;
    logic                 w_store;
    logic                 w_out_free;
    logic                 w_is_last;
    logic [LCS_CNT_W-1:0] n_vowel_total;
    logic [LCS_CNT_W-1:0] n_cons_total;

    assign w_seq_bin = LCS_ORDER[r_idx];
    assign w_rd_addr = i_cmd.accept ? letter_bin(i_char_code) : w_seq_bin;
    assign w_rd_cnt  = r_rd_hit ? r_rd_data : '0;
    assign w_total   = LCS_TOT_W'(r_vowel_total) + LCS_TOT_W'(r_cons_total);
    assign w_room    = w_total < LCS_TOT_W'(MAX_LETTERS);
    assign w_store   = i_cmd.update && r_is_letter && w_room;
    assign w_out_free = !r_o_valid || !i_stall;
    assign w_is_last = (LCS_TOT_W'(r_emitted) + LCS_TOT_W'(1)) == w_total;

    always_comb begin
        n_vowel_total = r_vowel_total;
        n_cons_total  = r_cons_total;
        if (w_store) begin
            if (r_is_vowel) begin
                n_vowel_total = r_vowel_total + LCS_CNT_W'(1);
            end else begin
                n_cons_total = r_cons_total + LCS_CNT_W'(1);
            end
        end
    end

    // histogram memory
    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_hist[r_bin] <= w_rd_cnt + LCS_CNT_W'(1);
        end
        if (i_cmd.accept || i_cmd.seq_read) begin
            r_rd_data <= r_hist[w_rd_addr];
            r_rd_hit  <= r_bin_valid[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_valid   <= '0;
            r_vowel_total <= '0;
            r_cons_total  <= '0;
            r_overflow    <= 1'b0;
            r_o_valid     <= 1'b0;
        end else begin
            if (i_cmd.clear_all) begin
                r_bin_valid   <= '0;
                r_vowel_total <= '0;
                r_cons_total  <= '0;
                r_overflow    <= 1'b0;
            end else begin
                if (w_store) begin
                    r_bin_valid[r_bin] <= 1'b1;
                end
                if (i_cmd.update && r_is_letter && !w_room) begin
                    r_overflow <= 1'b1;
                end
                r_vowel_total <= n_vowel_total;
                r_cons_total  <= n_cons_total;
            end
            if (i_cmd.emit || i_cmd.emit_empty) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_bin       <= letter_bin(i_char_code);
            r_is_letter <= is_letter(i_char_code);
            r_is_vowel  <= is_vowel(i_char_code);
            r_eot       <= i_end_of_text;
        end
        if (i_cmd.seq_clear) begin
            r_idx     <= '0;
            r_emitted <= '0;
        end else begin
            if (i_cmd.next_bin) begin
                r_idx <= r_idx + LCS_BIN_W'(1);
            end
            if (i_cmd.emit) begin
                r_emitted <= r_emitted + LCS_CNT_W'(1);
            end
        end
        if (i_cmd.take_cnt) begin
            r_left <= w_rd_cnt;
        end else if (i_cmd.emit) begin
            r_left <= r_left - LCS_CNT_W'(1);
        end
        if (i_cmd.emit) begin
            r_letter      <= bin_code(w_seq_bin);
            if (r_idx >= LCS_BIN_W'(LCS_NUM_VOWEL_BINS)) begin
                r_group       <= LCS_GRP_CONSONANT;
                r_group_count <= r_cons_total;
            end else begin
                r_group       <= LCS_GRP_VOWEL;
                r_group_count <= r_vowel_total;
            end
            r_overflowed  <= r_overflow;
            r_empty_text  <= 1'b0;
            r_last_result <= w_is_last;
        end else if (i_cmd.emit_empty) begin
            r_letter      <= '0;
            r_group       <= LCS_GRP_VOWEL;
            r_group_count <= '0;
            r_overflowed  <= r_overflow;
            r_empty_text  <= 1'b1;
            r_last_result <= 1'b1;
        end
    end

    always_comb begin
        o_status.eot        = r_eot;
        o_status.total_zero = (n_vowel_total == '0) && (n_cons_total == '0);
        o_status.cnt_zero   = w_rd_cnt == '0;
        o_status.left_one   = r_left == LCS_CNT_W'(1);
        o_status.last_bin   = r_idx == LCS_BIN_W'(LCS_NUM_BINS - 1);
        o_status.is_last    = w_is_last;
        o_status.out_free   = w_out_free;
    end

    assign o_valid       = r_o_valid;
    assign o_letter      = r_letter;
    assign o_group       = r_group;
    assign o_group_count = r_group_count;
    assign o_overflowed  = r_overflowed;
    assign o_empty_text  = r_empty_text;
    assign o_last_result = r_last_result;

    a_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_total <= LCS_TOT_W'(MAX_LETTERS))
        else $error("stored letters exceed capacity");

    a_empty_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_empty_text) |-> (r_last_result && (r_letter == '0)))
        else $error("empty result malformed");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear_all |=> ((r_vowel_total == '0) && (r_cons_total == '0) &&
                             (r_bin_valid == '0) && !r_overflow))
        else $error("state not cleared after emit");

endmodule

// ===== design/lcs_ctrl.sv =====
// ----------------------------------------------------------------------------
// lcs_ctrl
// Controller of the letter class sort block: input load and histogram update,
// then the sorted emit walk over the histogram bins or an empty-text result.
// ----------------------------------------------------------------------------
module lcs_ctrl
    import lcs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_stall
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_EMPTY,
        S_RD,
        S_CHK,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_stall;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.update    = 1'b1;
                o_cmd.seq_clear = 1'b1;
                if (!i_status.eot) begin
                    n_state = S_IDLE;
                end else if (i_status.total_zero) begin
                    n_state = S_EMPTY;
                end else begin
                    n_state = S_RD;
                end
            end
            S_EMPTY: begin
                if (i_status.out_free) begin
                    o_cmd.emit_empty = 1'b1;
                    o_cmd.clear_all  = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_RD: begin
                o_cmd.seq_read = 1'b1;
                n_state        = S_CHK;
            end
            S_CHK: begin
                if (!i_status.cnt_zero) begin
                    o_cmd.take_cnt = 1'b1;
                    n_state        = S_OUT;
                end else if (i_status.last_bin) begin
                    o_cmd.clear_all = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    o_cmd.next_bin = 1'b1;
                    n_state        = S_RD;
                end
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.is_last) begin
                        o_cmd.clear_all = 1'b1;
                        n_state         = S_IDLE;
                    end else if (i_status.left_one) begin
                        o_cmd.next_bin = 1'b1;
                        n_state        = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stall <= 1'b0;
        end else begin
            r_state <= n_state;
            r_stall <= n_state != S_IDLE;
        end
    end

    assign o_stall = r_stall;

    a_stall_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stall == (r_state != S_IDLE))
        else $error("stall out of step with state");

    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && i_status.is_last) |=> (r_state == S_IDLE))
        else $error("emit walk did not end on last result");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit || o_cmd.emit_empty) |-> i_status.out_free)
        else $error("result emitted into a stalled output register");

endmodule

// ===== design/letter_class_sort_core.sv =====
// a byte is taken by an accept, then a histogram read-modify-write
// end of text: each bin walked is read and checked, each result emitted,
// at most 52 bins, held by output stalls; no byte is taken during the walk
// a new byte is taken only after the last one has updated the histogram
// reset: synchronous active low; clears totals, overflow flag and bin valids
// ----------------------------------------------------------------------------
// letter_class_sort_core
// Vowel / consonant split counting sort of the ASCII letters of a text.
// ----------------------------------------------------------------------------
module letter_class_sort_core
    import lcs_pkg::*;
#(
    parameter int MAX_LETTERS = LCS_MAX_LETTERS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [7:0]           i_char_code,
    input  logic                 i_end_of_text,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [6:0]           o_letter,
    output logic                 o_group,
    output logic [LCS_CNT_W-1:0] o_group_count,
    output logic                 o_overflowed,
    output logic                 o_empty_text,
    output logic                 o_last_result
);

    t_cmd    w_cmd;
    t_status w_status;

    lcs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_stall  (o_stall)
    );

    lcs_datapath #(
        .MAX_LETTERS (MAX_LETTERS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_char_code   (i_char_code),
        .i_end_of_text (i_end_of_text),
        .i_stall       (i_stall),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_valid       (o_valid),
        .o_letter      (o_letter),
        .o_group       (o_group),
        .o_group_count (o_group_count),
        .o_overflowed  (o_overflowed),
        .o_empty_text  (o_empty_text),
        .o_last_result (o_last_result)
    );

endmodule
